[src/depth_preferred_hash_table_unit_assert.svh]
// Assertion macros for the hash table unit. Each expects clk and rst_n in scope.
`ifndef DEPTH_PREFERRED_HASH_TABLE_UNIT_ASSERT_SVH
`define DEPTH_PREFERRED_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dpht_pkg.sv]
package dpht_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] FUNC_PROBE = 2'd0;
    localparam logic [1:0] FUNC_STORE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam logic signed [7:0] EMPTY_DEPTH = -8'sd1;

    typedef struct packed {
        logic [1:0]          func;
        logic [63:0]         key;
        logic signed [7:0]   search_depth;
        logic signed [15:0]  alpha;
        logic signed [15:0]  beta;
        logic signed [15:0]  new_score;
        logic [1:0]          bound_kind;
        logic [31:0]         move_word;
    } request_t;

    typedef struct packed {
        logic                score_hit;
        logic signed [15:0]  hit_score;
        logic                key_matched;
        logic [31:0]         best_move;
        logic                written;
    } response_t;

    typedef struct packed {
        logic [63:0]         key;
        logic signed [7:0]   depth;
        logic signed [15:0]  score;
        logic [1:0]          bound;
        logic [31:0]         move;
    } entry_t;

    typedef struct packed {
        logic                entry_we;
        logic                valid_we;
        logic                valid;
        logic [IDX_W-1:0]    idx;
        entry_t              entry;
    } slot_wr_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_CLEAR
    } state_t;

endpackage

[src/dpht_slot_mem.sv]
module dpht_slot_mem (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [dpht_pkg::IDX_W-1:0] rd_idx,
    output dpht_pkg::entry_t        rd_entry,
    output logic                    rd_valid,
    input  dpht_pkg::slot_wr_t      wr
);

    dpht_pkg::entry_t entry_mem [dpht_pkg::TABLE_ENTRIES];
    logic             valid_mem [dpht_pkg::TABLE_ENTRIES];

    dpht_pkg::entry_t rd_entry_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.entry_we)
        begin
            entry_mem[wr.idx] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid_we)
        begin
            valid_mem[wr.idx] <= wr.valid;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[src/depth_preferred_hash_table_unit.sv]
// Channel     Handshake            Payload                 Notes
// ---------   ------------------   ---------------------   -----------------------------
// command     start / busy         request (request_t)     taken when start && !busy
// result      done (1-cycle pulse) response (response_t)  no back-pressure
// config      null_move_we         null_move_data [31:0]   write only, idle time only
//
// Probe and store: the item is taken, the entry is read from the slot memory on that edge,
// the next cycle compares and writes back, and done pulses in the cycle after that; a new item is
// taken only once the unit is back in idle, as busy stays high through the lookup.
// Clear: the valid memory is swept one entry a cycle, and done pulses when the sweep ends.
// After reset the same sweep runs with busy high, and no done pulse is given.
// The result is shown for one cycle and the receiver cannot stall it.
`include "depth_preferred_hash_table_unit_assert.svh"

module depth_preferred_hash_table_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dpht_pkg::request_t   request,
    output logic                 done,
    output dpht_pkg::response_t  response,
    input  logic                 null_move_we,
    input  logic [31:0]          null_move_data
);

    dpht_pkg::state_t    state_reg, state_next;
    logic [dpht_pkg::IDX_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    dpht_pkg::request_t  req_reg, req_next;
    dpht_pkg::response_t result_reg, result_next;
    logic                done_reg, done_next;
    logic [31:0]         null_move_reg, null_move_next;

    logic                accept;
    logic                rd_en;
    dpht_pkg::entry_t    rd_entry;
    logic                rd_valid;
    dpht_pkg::slot_wr_t  slot_wr;

    logic [63:0]         e_key;
    logic signed [7:0]   e_depth;
    logic signed [15:0]  e_score;
    logic [1:0]          e_bound;
    logic [31:0]         e_move;
    logic                key_eq;
    logic                depth_ok;
    logic                bound_ok;
    logic                store_ok;

    dpht_slot_mem u_slot_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_idx   (request.key[dpht_pkg::IDX_W-1:0]),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr       (slot_wr)
    );

    assign busy   = (state_reg != dpht_pkg::ST_IDLE);
    assign accept = start && !busy;

    // An empty entry reads as key zero, depth -1, score zero, exact bound, null move.
    always_comb
    begin
        if (rd_valid)
        begin
            e_key   = rd_entry.key;
            e_depth = rd_entry.depth;
            e_score = rd_entry.score;
            e_bound = rd_entry.bound;
            e_move  = rd_entry.move;
        end
        else
        begin
            e_key   = '0;
            e_depth = dpht_pkg::EMPTY_DEPTH;
            e_score = '0;
            e_bound = dpht_pkg::BOUND_EXACT;
            e_move  = null_move_reg;
        end
        key_eq   = (e_key == req_reg.key);
        depth_ok = (e_depth >= req_reg.search_depth);
        case (e_bound)
            dpht_pkg::BOUND_EXACT: bound_ok = 1'b1;
            dpht_pkg::BOUND_LOWER: bound_ok = (e_score >= req_reg.beta);
            dpht_pkg::BOUND_UPPER: bound_ok = (e_score <= req_reg.alpha);
            default:               bound_ok = 1'b0;
        endcase
        store_ok = !rd_valid || (e_key == 64'd0) || key_eq
                   || (req_reg.search_depth >= e_depth);
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        req_next       = req_reg;
        result_next    = '0;
        done_next      = 1'b0;
        null_move_next = null_move_we ? null_move_data : null_move_reg;
        rd_en          = 1'b0;

        slot_wr          = '0;
        slot_wr.idx      = req_reg.key[dpht_pkg::IDX_W-1:0];
        slot_wr.valid    = 1'b1;
        slot_wr.entry.key   = req_reg.key;
        slot_wr.entry.depth = req_reg.search_depth;
        slot_wr.entry.score = req_reg.new_score;
        slot_wr.entry.bound = req_reg.bound_kind;
        slot_wr.entry.move  = req_reg.move_word;

        unique case (state_reg)
            dpht_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next       = request;
                    rd_en          = 1'b1;
                    sweep_cnt_next = '0;
                    if (request.func == dpht_pkg::FUNC_CLEAR)
                    begin
                        state_next = dpht_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = dpht_pkg::ST_LOOKUP;
                    end
                end
            end
            dpht_pkg::ST_LOOKUP:
            begin
                case (req_reg.func)
                    dpht_pkg::FUNC_PROBE:
                    begin
                        result_next.best_move = null_move_reg;
                        if (key_eq)
                        begin
                            result_next.key_matched = 1'b1;
                            result_next.best_move   = e_move;
                            if (depth_ok && bound_ok)
                            begin
                                result_next.score_hit = 1'b1;
                                result_next.hit_score = e_score;
                            end
                        end
                    end
                    dpht_pkg::FUNC_STORE:
                    begin
                        if (store_ok)
                        begin
                            slot_wr.entry_we    = 1'b1;
                            slot_wr.valid_we    = 1'b1;
                            result_next.written = 1'b1;
                        end
                    end
                    default:
                    begin
                        result_next = '0;
                    end
                endcase
                done_next  = 1'b1;
                state_next = dpht_pkg::ST_IDLE;
            end
            dpht_pkg::ST_INIT,
            dpht_pkg::ST_CLEAR:
            begin
                // Drop one valid bit a cycle.
                slot_wr.idx      = sweep_cnt_reg;
                slot_wr.valid    = 1'b0;
                slot_wr.valid_we = 1'b1;
                sweep_cnt_next   = sweep_cnt_reg + 1'b1;
                if (&sweep_cnt_reg)
                begin
                    state_next = dpht_pkg::ST_IDLE;
                    done_next  = (state_reg == dpht_pkg::ST_CLEAR);
                end
            end
            default:
            begin
                state_next = dpht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpht_pkg::ST_INIT;
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
            null_move_reg <= 32'hFFFF_FFFF;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= done_next;
            null_move_reg <= null_move_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign done     = done_reg;
    assign response = result_reg;

    `DPHT_ASSERT_NEXT(a_accept_busy, accept, busy, "busy low after an accepted item")
    `DPHT_ASSERT_NOW(a_done_source, done, $past(state_reg == dpht_pkg::ST_LOOKUP) || ($past(state_reg == dpht_pkg::ST_CLEAR) && $past(&sweep_cnt_reg)), "done without a finished item")
    `DPHT_ASSERT_NOW(a_entry_write_store, slot_wr.entry_we, (state_reg == dpht_pkg::ST_LOOKUP) && (req_reg.func == dpht_pkg::FUNC_STORE), "entry written outside a store")
    `DPHT_ASSERT_NOW(a_written_alone, done && response.written, !response.key_matched && !response.score_hit, "store result carries probe fields")

endmodule
